FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mfwi_pkg.sv
// ----------------------------------------------------------------------------
// MLP inference package
// Widths, weight ROM, stage-enable type and constant helper functions.
// ----------------------------------------------------------------------------
package mfwi_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int ACT_W     = 18;
    localparam int WGT_W     = 21;
    localparam int PROD_W    = ACT_W + WGT_W;
    localparam int ACC_W     = 44;
    localparam int ARG_W     = 21;
    localparam int FRAC_W    = 20;
    localparam int ARG_LIMIT = 524288;
    localparam int ROM_WORDS = 125;

    localparam int ACT_TABLE_ENTRIES_DEF = 256;

    localparam int MAC_STAGES = 3;
    localparam int LUT_STAGES = 4;
    localparam int STAGES_PER_LAYER = MAC_STAGES + LUT_STAGES;

    localparam int BASE_B1  = 0;
    localparam int BASE_B2  = 24;
    localparam int BASE_B3  = 36;
    localparam int BASE_MRG = 40;
    localparam int BASE_OUT = 118;

    localparam longint unsigned ONE_Q31 = 64'd2147483648;

    typedef logic signed [ACT_W-1:0] act_t;
    typedef logic signed [WGT_W-1:0] weight_t;

    typedef struct packed {
        logic [LUT_STAGES-1:0] act;
        logic [MAC_STAGES-1:0] mac;
    } stage_en_t;

    // Weights and biases in units of 1e-9, neuron by neuron, bias last.
    localparam longint ROM_NANO [ROM_WORDS] = '{
        64'sd334525270, 64'sd2327294605, -64'sd1082180403, -64'sd1834963860,
        -64'sd132942684, -64'sd2074350670, -64'sd7717231032, 64'sd316815191,
        -64'sd961228915, -64'sd1594517235, 64'sd7642756516, 64'sd908207828,
        -64'sd138149619, -64'sd369268995, -64'sd1058780215, 64'sd243157631,
        -64'sd830754366, -64'sd1142978109, -64'sd591263861, 64'sd227502338,
        -64'sd2352347649, -64'sd170592638, 64'sd6456235547, -64'sd5963861504,
        -64'sd461376663, -64'sd2296805006, 64'sd1766718541,
        64'sd1141895797, 64'sd3601222163, -64'sd444519187,
        64'sd5139657269, -64'sd8540243578, 64'sd277820653,
        64'sd797602696, 64'sd9041321116, 64'sd951326827,
        -64'sd3808463572, 64'sd1980489641,
        64'sd6097049863, -64'sd1473609599,
        -64'sd682425988, 64'sd2203515317, 64'sd1390971669, -64'sd2391242036,
        64'sd2279866103, -64'sd633039777, 64'sd1739401176, 64'sd4312571637,
        64'sd2009089958, 64'sd542330032, -64'sd1842026297, -64'sd877541434,
        64'sd5180588,
        -64'sd478344057, 64'sd2225421590, 64'sd1324254173, -64'sd2910864489,
        64'sd2553668255, 64'sd915264602, 64'sd1827164778, 64'sd3905022027,
        64'sd1712605648, 64'sd673923447, -64'sd1960903941, -64'sd946074756,
        64'sd1702249385,
        -64'sd330288478, 64'sd636650781, -64'sd267485766, -64'sd84595782,
        -64'sd31175096, 64'sd519857879, -64'sd297770957, 64'sd353599592,
        -64'sd33562862, 64'sd1903594079, 64'sd17335633, -64'sd9696151,
        -64'sd1493864902,
        64'sd871647922, -64'sd36365306, -64'sd1234899386, 64'sd3487355277,
        -64'sd4092045643, -64'sd1291243338, 64'sd211761429, -64'sd1376121211,
        -64'sd303662472, 64'sd1133293789, -64'sd83956813, -64'sd129727081,
        -64'sd493522599,
        -64'sd1145786277, 64'sd362029723, -64'sd1496530522, -64'sd2143165463,
        64'sd2537195718, 64'sd1035451663, -64'sd299078423, 64'sd649961869,
        64'sd173313681, 64'sd573538753, 64'sd35654777, 64'sd69116974,
        64'sd783198078,
        -64'sd3934248356, -64'sd140516448, -64'sd287183959, 64'sd2810565867,
        -64'sd1137960529, -64'sd1610326791, -64'sd3387100421, 64'sd1164487482,
        -64'sd60734989, -64'sd2011821477, 64'sd330775400, 64'sd72397537,
        -64'sd861886991,
        -64'sd4606874390, 64'sd4688106582, 64'sd7488541587, -64'sd2673496459,
        -64'sd5845936418, -64'sd1133133706, 64'sd222585256
    };

    // Q16 weight, rounded with ties away from zero.
    function automatic weight_t rom_q16(input int idx);
        longint w;
        longint unsigned mag;
        longint unsigned q;
        w   = ROM_NANO[idx];
        mag = (w < 0) ? longint'(-w) : w;
        q   = (mag * 64'd65536 + 64'd500000000) / 64'd1000000000;
        return (w < 0) ? WGT_W'(-longint'(q)) : WGT_W'(longint'(q));
    endfunction

    // One rounded squaring of a Q31 value.
    function automatic longint unsigned sq_q31(input longint unsigned v);
        return (v * v + (64'd1 << 30)) >> 31;
    endfunction

endpackage

FILE: rtl/core/mlp_fixed_weight_inference_unit.sv
// ----------------------------------------------------------------------------
// Fixed-weight MLP inference unit
// Three-branch tanh network, merge layer and sigmoid output, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Word
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_stall  | in1_a in1_b in1_c in2_a in2_b in3, Q2.14
//  output  | out_valid / out_stall| ann_out, unsigned Q0.16
//
// One word is accepted per cycle while in_stall is low. There are 22 register
// stages: one input register, then seven stages for each of the three layers
// (three for multiply, group sum and round/clamp, four for the table lookup
// and interpolation). The accepting edge loads the first of them.
// Reset clears only the stage valid bits; the tables and weights are constant.
// A stall on the output holds the last stage; empty stages behind it still
// advance, so the input is stalled only once every stage holds a word.
//
`include "assert_macros.svh"

module mlp_fixed_weight_inference_unit #(
    parameter int ACT_TABLE_ENTRIES = mfwi_pkg::ACT_TABLE_ENTRIES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in1_a,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in1_b,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in1_c,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in2_a,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in2_b,
    input  logic signed [mfwi_pkg::IN_W-1:0]     in3,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mfwi_pkg::OUT_W-1:0]           ann_out
);
    import mfwi_pkg::*;

    localparam int DEPTH = 1 + 3 * STAGES_PER_LAYER;

    // Stage enables ripple back from the output: a stage loads when it is
    // empty or when the stage after it loads as well.
    logic [DEPTH:0]   en;
    logic [DEPTH-1:0] vld_reg, vld_next;

    assign en[DEPTH] = ~out_stall;
    for (genvar i = 0; i < DEPTH; i++) begin : g_en
        assign en[i] = ~vld_reg[i] | en[i+1];
    end

    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_next[i];
            end
        end
    end

    assign in_stall  = ~en[0];
    assign out_valid = vld_reg[DEPTH-1];

    // Input register: features widened from Q2.14 to Q16.
    act_t br1_reg [3];
    act_t br2_reg [2];
    act_t br3_reg [1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            br1_reg[0] <= {in1_a, 2'b00};
            br1_reg[1] <= {in1_b, 2'b00};
            br1_reg[2] <= {in1_c, 2'b00};
            br2_reg[0] <= {in2_a, 2'b00};
            br2_reg[1] <= {in2_b, 2'b00};
            br3_reg[0] <= {in3, 2'b00};
        end
    end

    stage_en_t en_l1, en_l2, en_l3;

    assign en_l1 = {en[1+MAC_STAGES +: LUT_STAGES], en[1 +: MAC_STAGES]};
    assign en_l2 = {en[1+STAGES_PER_LAYER+MAC_STAGES +: LUT_STAGES],
                    en[1+STAGES_PER_LAYER +: MAC_STAGES]};
    assign en_l3 = {en[1+2*STAGES_PER_LAYER+MAC_STAGES +: LUT_STAGES],
                    en[1+2*STAGES_PER_LAYER +: MAC_STAGES]};

    // Hidden layer: branch one feeds h[0..5], branch two h[6..9], branch three h[10..11].
    act_t h [12];
    act_t g [6];
    act_t yo;

    for (genvar i = 0; i < 6; i++) begin : g_b1
        mfwi_neuron #(.NIN(3), .ROM_BASE(BASE_B1 + 4 * i),
                      .ACT_TABLE_ENTRIES(ACT_TABLE_ENTRIES), .IS_SIG(1'b0))
            u_n (.clk(clk), .en(en_l1), .x(br1_reg), .y(h[i]));
    end

    for (genvar i = 0; i < 4; i++) begin : g_b2
        mfwi_neuron #(.NIN(2), .ROM_BASE(BASE_B2 + 3 * i),
                      .ACT_TABLE_ENTRIES(ACT_TABLE_ENTRIES), .IS_SIG(1'b0))
            u_n (.clk(clk), .en(en_l1), .x(br2_reg), .y(h[6+i]));
    end

    for (genvar i = 0; i < 2; i++) begin : g_b3
        mfwi_neuron #(.NIN(1), .ROM_BASE(BASE_B3 + 2 * i),
                      .ACT_TABLE_ENTRIES(ACT_TABLE_ENTRIES), .IS_SIG(1'b0))
            u_n (.clk(clk), .en(en_l1), .x(br3_reg), .y(h[10+i]));
    end

    // Merge layer of six tanh neurons over all twelve hidden values.
    for (genvar i = 0; i < 6; i++) begin : g_mrg
        mfwi_neuron #(.NIN(12), .ROM_BASE(BASE_MRG + 13 * i),
                      .ACT_TABLE_ENTRIES(ACT_TABLE_ENTRIES), .IS_SIG(1'b0))
            u_n (.clk(clk), .en(en_l2), .x(h), .y(g[i]));
    end

    // Sigmoid output neuron.
    mfwi_neuron #(.NIN(6), .ROM_BASE(BASE_OUT),
                  .ACT_TABLE_ENTRIES(ACT_TABLE_ENTRIES), .IS_SIG(1'b1))
        u_out (.clk(clk), .en(en_l3), .x(g), .y(yo));

    // A sigmoid of exactly one does not fit Q0.16 and is clipped to all ones.
    always_comb
    begin
        priority if (yo > ACT_W'(65535))
            ann_out = '1;
        else if (yo < ACT_W'(0))
            ann_out = '0;
        else
            ann_out = yo[OUT_W-1:0];
    end

    `ASSERT_IMPLY(a_stall_full, in_stall, ((&vld_reg) && out_stall),
        "input stalled although the pipeline has a free stage")
    `ASSERT_NEXT(a_accept_enters, (in_valid && !in_stall), vld_reg[0],
        "accepted word did not enter the first stage")
    `ASSERT_NEXT(a_hold_result, (out_valid && out_stall),
        (out_valid && $stable(yo)),
        "waiting result changed or vanished under stall")

endmodule

FILE: rtl/core/mfwi_act.sv
// ----------------------------------------------------------------------------
// Activation lookup
// Four-stage tanh or sigmoid table lookup with linear interpolation.
// ----------------------------------------------------------------------------
module mfwi_act #(
    parameter int ACT_TABLE_ENTRIES = mfwi_pkg::ACT_TABLE_ENTRIES_DEF,
    parameter bit IS_SIG            = 1'b0
) (
    input  logic                                    clk,
    input  logic [mfwi_pkg::LUT_STAGES-1:0]         en,
    input  logic signed [mfwi_pkg::ARG_W-1:0]       arg,
    output mfwi_pkg::act_t                          y
);
    import mfwi_pkg::*;

    localparam int IDX_W = $clog2(ACT_TABLE_ENTRIES + 1);
    localparam int POS_W = FRAC_W + IDX_W;
    localparam int DIF_W = ACT_W + 1;
    localparam int MUL_W = DIF_W + FRAC_W + 1;

    act_t tab [0:ACT_TABLE_ENTRIES];

    // Table points over [-8, +8], built at elaboration from a Q31 exponential.
    for (genvar k = 0; k <= ACT_TABLE_ENTRIES; k++) begin : g_tab
        localparam longint DX = 16 * k - 8 * ACT_TABLE_ENTRIES;
        localparam longint unsigned AD  = (DX < 0) ? -DX : DX;
        localparam longint unsigned NUM = IS_SIG ? AD : 2 * AD;
        localparam longint unsigned T0  =
            ((NUM << 31) + ACT_TABLE_ENTRIES / 2) / ACT_TABLE_ENTRIES;
        localparam longint unsigned U1 = T0 >> 8;
        localparam longint unsigned U2 = (U1 * U1) >> 31;
        localparam longint unsigned U3 = (U2 * U1) >> 31;
        localparam longint unsigned U4 = (U3 * U1) >> 31;
        localparam longint unsigned V0 = ONE_Q31 - U1 + U2 / 2 - U3 / 6 + U4 / 24;
        localparam longint unsigned EX = sq_q31(sq_q31(sq_q31(sq_q31(
            sq_q31(sq_q31(sq_q31(sq_q31(V0))))))));
        localparam longint unsigned DEN   = ONE_Q31 + EX;
        localparam longint unsigned S_POS = ((64'd1 << 47) + DEN / 2) / DEN;
        localparam longint unsigned S_NEG = (EX * 64'd65536 + DEN / 2) / DEN;
        localparam longint unsigned TT    =
            ((ONE_Q31 - EX) * 64'd65536 + DEN / 2) / DEN;
        localparam longint SVAL = (DX >= 0) ? longint'(S_POS) : longint'(S_NEG);
        localparam longint TVAL = (DX < 0) ? -longint'(TT) : longint'(TT);
        assign tab[k] = IS_SIG ? ACT_W'(SVAL) : ACT_W'(TVAL);
    end

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ARG_W-1:0]        off;
    act_t                    lo_reg, lo_next, hi_reg, hi_next, base_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [IDX_W-1:0]        idx;
    logic signed [DIF_W-1:0] diff;
    logic signed [MUL_W-1:0] mul_reg, mul_next;
    logic signed [DIF_W-1:0] step;
    act_t                    y_reg, y_next;

    // Stage one: scale the offset argument onto the table grid.
    assign off      = arg + ARG_W'(ARG_LIMIT);
    assign pos_next = POS_W'(off) * POS_W'(ACT_TABLE_ENTRIES);

    // Stage two: fetch both neighbours; at the top end the last point is used twice.
    assign idx = pos_reg[POS_W-1:FRAC_W];
    always_comb
    begin
        if (idx >= IDX_W'(ACT_TABLE_ENTRIES))
        begin
            lo_next = tab[ACT_TABLE_ENTRIES];
            hi_next = tab[ACT_TABLE_ENTRIES];
        end
        else
        begin
            lo_next = tab[idx];
            hi_next = tab[idx + IDX_W'(1)];
        end
    end

    // Stage three: slope times fraction.
    assign diff     = DIF_W'(hi_reg) - DIF_W'(lo_reg);
    assign mul_next = MUL_W'(diff) * MUL_W'($signed({1'b0, frac_reg}));

    // Stage four: rounded interpolation.
    assign step   = DIF_W'((mul_reg + MUL_W'(1 << (FRAC_W - 1))) >>> FRAC_W);
    assign y_next = ACT_W'(DIF_W'(base_reg) + step);

    always_ff @(posedge clk)
    begin
        if (en[0])
            pos_reg <= pos_next;
        if (en[1])
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            frac_reg <= pos_reg[FRAC_W-1:0];
        end
        if (en[2])
        begin
            mul_reg  <= mul_next;
            base_reg <= lo_reg;
        end
        if (en[3])
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

FILE: rtl/core/mfwi_neuron.sv
// ----------------------------------------------------------------------------
// Neuron
// Three-stage multiply-accumulate with rounding and saturation, then activation.
// ----------------------------------------------------------------------------
module mfwi_neuron #(
    parameter int NIN               = 3,
    parameter int ROM_BASE          = 0,
    parameter int ACT_TABLE_ENTRIES = mfwi_pkg::ACT_TABLE_ENTRIES_DEF,
    parameter bit IS_SIG            = 1'b0
) (
    input  logic                clk,
    input  mfwi_pkg::stage_en_t en,
    input  mfwi_pkg::act_t      x [NIN],
    output mfwi_pkg::act_t      y
);
    import mfwi_pkg::*;

    localparam int NGRP  = (NIN + 3) / 4;
    localparam int GRP_W = PROD_W + 2;
    localparam weight_t BIAS = rom_q16(ROM_BASE + NIN);
    localparam logic signed [ACC_W-1:0] BIAS_Q32 = ACC_W'(longint'(BIAS) * 65536);

    logic signed [PROD_W-1:0] prod_reg [NIN];
    logic signed [PROD_W-1:0] prod_next [NIN];
    logic signed [PROD_W-1:0] prod_pad [NGRP*4];
    logic signed [GRP_W-1:0]  grp_reg [NGRP];
    logic signed [GRP_W-1:0]  grp_next [NGRP];
    logic signed [GRP_W-1:0]  grp_pad [4];
    logic signed [ACC_W-1:0]  acc, rnd;
    logic signed [ARG_W-1:0]  arg_reg, arg_next;

    for (genvar j = 0; j < NIN; j++) begin : g_mul
        localparam weight_t WJ = rom_q16(ROM_BASE + j);
        assign prod_next[j] = PROD_W'(x[j]) * PROD_W'(WJ);
    end

    for (genvar j = 0; j < NGRP * 4; j++) begin : g_pad
        if (j < NIN) begin : g_used
            assign prod_pad[j] = prod_reg[j];
        end else begin : g_zero
            assign prod_pad[j] = '0;
        end
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        assign grp_next[g] = GRP_W'(prod_pad[4*g])   + GRP_W'(prod_pad[4*g+1])
                           + GRP_W'(prod_pad[4*g+2]) + GRP_W'(prod_pad[4*g+3]);
    end

    for (genvar g = 0; g < 4; g++) begin : g_gpad
        if (g < NGRP) begin : g_used
            assign grp_pad[g] = grp_reg[g];
        end else begin : g_zero
            assign grp_pad[g] = '0;
        end
    end

    // Bias in Q32, round to Q16 by adding one half and flooring, then clamp to +-8.
    assign acc = BIAS_Q32 + ACC_W'(grp_pad[0]) + ACC_W'(grp_pad[1])
               + ACC_W'(grp_pad[2]) + ACC_W'(grp_pad[3]);
    assign rnd = (acc + ACC_W'(32768)) >>> 16;

    always_comb
    begin
        priority if (rnd > ACC_W'(ARG_LIMIT))
            arg_next = ARG_W'(ARG_LIMIT);
        else if (rnd < -ACC_W'(ARG_LIMIT))
            arg_next = -ARG_W'(ARG_LIMIT);
        else
            arg_next = ARG_W'(rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en.mac[0])
            prod_reg <= prod_next;
        if (en.mac[1])
            grp_reg <= grp_next;
        if (en.mac[2])
            arg_reg <= arg_next;
    end

    mfwi_act #(
        .ACT_TABLE_ENTRIES (ACT_TABLE_ENTRIES),
        .IS_SIG            (IS_SIG)
    ) u_act (
        .clk (clk),
        .en  (en.act),
        .arg (arg_reg),
        .y   (y)
    );

endmodule
